>>> rtl/core/wtsc_pkg.sv
// Package for the wave-table sound channel: beat types, command and lock codes,
// controller/datapath interface structs and the timer period helper. No dependencies.
`default_nettype none

package wtsc_pkg;

  localparam int TICK_W     = 13;
  localparam int WAVE_BYTES = 16;
  localparam int WADDR_W    = 4;
  localparam int FREQ_W     = 11;
  localparam int PERIOD_W   = 13;
  localparam int POS_W      = 5;
  localparam int VOL_W      = 3;

  localparam logic [2:0] CMD_REG   = 3'd0;
  localparam logic [2:0] CMD_WAVE  = 3'd1;
  localparam logic [2:0] CMD_RUN   = 3'd2;
  localparam logic [2:0] CMD_POFF  = 3'd3;
  localparam logic [2:0] CMD_PON   = 3'd4;

  localparam logic [2:0] REG_NR30  = 3'd0;
  localparam logic [2:0] REG_NR31  = 3'd1;
  localparam logic [2:0] REG_NR32  = 3'd2;
  localparam logic [2:0] REG_NR33  = 3'd3;
  localparam logic [2:0] REG_NR34  = 3'd4;

  localparam logic [1:0] LOCK_NORMAL = 2'd0;
  localparam logic [1:0] LOCK_SINGLE = 2'd1;
  localparam logic [1:0] LOCK_NONE   = 2'd2;

  localparam logic [VOL_W-1:0] VOL_MUTE = 3'd4;
  localparam logic [11:0]      FREQ_BASE = 12'd2048;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         reg_select;
    logic [WADDR_W-1:0] wave_address;
    logic [7:0]         write_data;
    logic [TICK_W-1:0]  tick_count;
  } wtsc_in_t;

  typedef struct packed {
    logic [3:0] sample_level;
    logic [1:0] lock_mode;
    logic [7:0] lock_byte;
    logic       channel_active;
  } wtsc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic fin;
    logic emit;
  } wtsc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic run_cmd;
    logic run_skip;
    logic expire;
  } wtsc_stat_t;

  // (2048 - f) * 2
  function automatic logic [PERIOD_W-1:0] period_of(input logic [FREQ_W-1:0] f);
    logic [11:0] diff;
    diff = FREQ_BASE - {1'b0, f};
    return {diff, 1'b0};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/wtsc_ctrl.sv
// Controller FSM of the wave-table sound channel: sequences accept, execute,
// timer expiry loop, window update and result strobe. Depends on wtsc_pkg.
`default_nettype none

module wtsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  output logic                     out_valid,
  output wtsc_pkg::wtsc_cmd_t      cmd,
  input  wire wtsc_pkg::wtsc_stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOOP = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.run_cmd && !stat.run_skip) state_nxt = S_LOOP;
        else state_nxt = S_RESP;
      end
      S_LOOP: begin
        if (stat.expire) cmd.step = 1'b1;
        else state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd.emit      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  a_fin_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (state_r == S_RESP && !out_valid_r))
    else $error("window update not followed by result");

endmodule

`default_nettype wire

>>> rtl/core/wtsc_dp.sv
// Datapath of the wave-table sound channel: wave RAM, channel registers, timer,
// sample position, read window, lock state and result register. Depends on wtsc_pkg.
`default_nettype none

module wtsc_dp #(
  parameter int MAX_TICKS = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wtsc_pkg::wtsc_in_t   in_item,
  input  wire wtsc_pkg::wtsc_cmd_t  cmd,
  output wtsc_pkg::wtsc_stat_t      stat,
  output wtsc_pkg::wtsc_out_t       out_item
);

  localparam int TMAX = (MAX_TICKS < 8191) ? MAX_TICKS : 8191;
  localparam int TW   = $clog2(((TMAX > 4096) ? TMAX : 4096) + 1) + 1;
  localparam logic [wtsc_pkg::TICK_W-1:0] TCLAMP = wtsc_pkg::TICK_W'(TMAX);
  localparam logic signed [TW-1:0] TWO = TW'(2);

  wtsc_pkg::wtsc_in_t  item_r, item_nxt;
  wtsc_pkg::wtsc_out_t out_r, out_nxt;

  logic [7:0] ram_r [wtsc_pkg::WAVE_BYTES];
  logic       ram_we;

  logic [wtsc_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic [wtsc_pkg::PERIOD_W-1:0] per_r, per_nxt;
  logic signed [TW-1:0]          tc_r, tc_nxt;
  logic signed [TW-1:0]          rw_r, rw_nxt;
  logic [wtsc_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [7:0]                    byte_r;
  logic [wtsc_pkg::VOL_W-1:0]    vol_r, vol_nxt;
  logic                          dac_r, dac_nxt;
  logic                          pwr_r, pwr_nxt;
  logic                          ch_r, ch_nxt;
  logic [1:0]                    lock_r, lock_nxt;
  logic                          exp_r, exp_nxt;

  logic [wtsc_pkg::TICK_W-1:0]   ticks;
  logic signed [TW-1:0]          t_s, per_s, rw_dec;
  logic [wtsc_pkg::FREQ_W-1:0]   f33, f34;
  logic [wtsc_pkg::PERIOD_W-1:0] per34;
  logic [wtsc_pkg::POS_W-1:0]    pos_inc;
  logic [1:0]                    vcode;
  logic [3:0]                    nib;

  assign ticks   = (item_r.tick_count > TCLAMP) ? TCLAMP : item_r.tick_count;
  assign t_s     = $signed({{(TW - wtsc_pkg::TICK_W){1'b0}}, ticks});
  assign per_s   = $signed({{(TW - wtsc_pkg::PERIOD_W){1'b0}}, per_r});
  assign rw_dec  = rw_r - t_s;
  assign f33     = {freq_r[10:8], item_r.write_data};
  assign f34     = {item_r.write_data[2:0], freq_r[7:0]};
  assign per34   = wtsc_pkg::period_of(f34);
  assign pos_inc = pos_r + 5'd1;
  assign vcode   = item_r.write_data[6:5];
  assign nib     = pos_r[0] ? byte_r[3:0] : byte_r[7:4];

  assign stat.run_cmd  = (item_r.command == wtsc_pkg::CMD_RUN);
  assign stat.run_skip = (per_r == '0) || !ch_r;
  assign stat.expire   = (tc_r <= 0);

  always_comb begin
    item_nxt = item_r;
    out_nxt  = out_r;
    freq_nxt = freq_r;
    per_nxt  = per_r;
    tc_nxt   = tc_r;
    rw_nxt   = rw_r;
    pos_nxt  = pos_r;
    vol_nxt  = vol_r;
    dac_nxt  = dac_r;
    pwr_nxt  = pwr_r;
    ch_nxt   = ch_r;
    lock_nxt = lock_r;
    exp_nxt  = exp_r;
    ram_we   = 1'b0;

    if (cmd.load) item_nxt = in_item;

    if (cmd.exec) begin
      case (item_r.command)
        wtsc_pkg::CMD_REG: begin
          if (pwr_r) begin
            unique case (item_r.reg_select)
              wtsc_pkg::REG_NR30: begin
                if (item_r.write_data[7]) begin
                  dac_nxt  = 1'b1;
                  lock_nxt = wtsc_pkg::LOCK_NONE;
                end else begin
                  dac_nxt  = 1'b0;
                  ch_nxt   = 1'b0;
                  lock_nxt = wtsc_pkg::LOCK_NORMAL;
                end
              end
              wtsc_pkg::REG_NR32: begin
                vol_nxt = (vcode == 2'd0) ? wtsc_pkg::VOL_MUTE : {1'b0, vcode - 2'd1};
              end
              wtsc_pkg::REG_NR33: begin
                freq_nxt = f33;
                per_nxt  = wtsc_pkg::period_of(f33);
              end
              wtsc_pkg::REG_NR34: begin
                freq_nxt = f34;
                per_nxt  = per34;
                if (item_r.write_data[7]) begin
                  rw_nxt  = '0;
                  tc_nxt  = $signed({{(TW - wtsc_pkg::PERIOD_W){1'b0}}, per34});
                  pos_nxt = '1;
                  ch_nxt  = dac_r;
                end
              end
              default: ;
            endcase
          end
        end
        wtsc_pkg::CMD_WAVE: begin
          if (lock_r == wtsc_pkg::LOCK_NORMAL) ram_we = 1'b1;
        end
        wtsc_pkg::CMD_RUN: begin
          if (stat.run_skip) begin
            lock_nxt = wtsc_pkg::LOCK_NORMAL;
          end else begin
            tc_nxt  = tc_r - t_s;
            exp_nxt = 1'b0;
          end
        end
        wtsc_pkg::CMD_POFF: begin
          if (pwr_r) begin
            pos_nxt  = '0;
            dac_nxt  = 1'b0;
            ch_nxt   = 1'b0;
            lock_nxt = wtsc_pkg::LOCK_NORMAL;
            vol_nxt  = wtsc_pkg::VOL_MUTE;
            freq_nxt = '0;
            per_nxt  = wtsc_pkg::period_of('0);
            pwr_nxt  = 1'b0;
          end
        end
        wtsc_pkg::CMD_PON: pwr_nxt = 1'b1;
        default: ;
      endcase
    end

    // one timer expiry; the byte fetch sits with the wave RAM
    if (cmd.step) begin
      pos_nxt  = pos_inc;
      lock_nxt = wtsc_pkg::LOCK_SINGLE;
      rw_nxt   = tc_r + TWO;
      exp_nxt  = 1'b1;
      tc_nxt   = tc_r + per_s;
    end

    // read window after the expiry loop
    if (cmd.fin) begin
      if (!exp_r && (rw_r > 0)) begin
        rw_nxt = rw_dec;
        if (rw_dec <= 0) lock_nxt = wtsc_pkg::LOCK_NONE;
      end else if (rw_r <= 0) begin
        lock_nxt = wtsc_pkg::LOCK_NONE;
      end
    end

    if (cmd.emit) begin
      out_nxt.sample_level   = (vol_r >= wtsc_pkg::VOL_MUTE) ? 4'd0 : (nib >> vol_r);
      out_nxt.lock_mode      = lock_r;
      out_nxt.lock_byte      = (lock_r == wtsc_pkg::LOCK_SINGLE) ? byte_r : 8'd0;
      out_nxt.channel_active = ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wtsc_pkg::WAVE_BYTES; i++) begin
        ram_r[i] <= i[0] ? 8'hff : 8'h00;
      end
      byte_r <= '0;
    end else begin
      if (ram_we) ram_r[item_r.wave_address] <= item_r.write_data;
      if (cmd.step) byte_r <= ram_r[pos_inc[wtsc_pkg::POS_W-1:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= '0;
      per_r  <= '0;
      tc_r   <= '0;
      rw_r   <= '0;
      pos_r  <= '0;
      vol_r  <= '0;
      dac_r  <= 1'b0;
      pwr_r  <= 1'b1;
      ch_r   <= 1'b0;
      lock_r <= wtsc_pkg::LOCK_NORMAL;
      exp_r  <= 1'b0;
    end else begin
      freq_r <= freq_nxt;
      per_r  <= per_nxt;
      tc_r   <= tc_nxt;
      rw_r   <= rw_nxt;
      pos_r  <= pos_nxt;
      vol_r  <= vol_nxt;
      dac_r  <= dac_nxt;
      pwr_r  <= pwr_nxt;
      ch_r   <= ch_nxt;
      lock_r <= lock_nxt;
      exp_r  <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_item = out_r;

  a_step_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (lock_r == wtsc_pkg::LOCK_SINGLE && exp_r))
    else $error("expiry did not open read window");

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    vol_r <= wtsc_pkg::VOL_MUTE)
    else $error("volume shift out of range");

  a_poff: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && item_r.command == wtsc_pkg::CMD_POFF && pwr_r)
      |=> (!ch_r && !dac_r && !pwr_r && lock_r == wtsc_pkg::LOCK_NORMAL))
    else $error("power off left channel state");

endmodule

`default_nettype wire

>>> rtl/core/wave_table_sound_channel.sv
// Top level of the wave-table sound channel: controller FSM plus datapath.
// Depends on wtsc_pkg, wtsc_ctrl and wtsc_dp.
//
// One beat is taken when start is high and busy is low; every beat gives exactly one
// result on out_item, marked by out_valid for a single cycle, and the receiver has no
// way to hold it off. A register write, wave RAM write, power-off, power-on, unknown
// command, or a tick run that finds the channel off or the period zero goes from accept
// through the execute state to the result state. A tick run on an active channel goes
// through the expiry loop between them, which advances the sample position and fetches
// one wave RAM byte per cycle while the timer has expired, and then the window update;
// with the shortest period of 2 ticks a run holds up to about MAX_TICKS/2 expiries.
// busy drops in the cycle of the result strobe, so the next beat can be accepted there.
`default_nettype none

module wave_table_sound_channel #(
  parameter int MAX_TICKS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire wtsc_pkg::wtsc_in_t in_item,
  output logic                    out_valid,
  output wtsc_pkg::wtsc_out_t     out_item
);

  wtsc_pkg::wtsc_cmd_t  cmd;
  wtsc_pkg::wtsc_stat_t stat;

  wtsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  wtsc_dp #(
    .MAX_TICKS (MAX_TICKS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
